### src/display_command_frame_parser_defines.svh
// Assertion macros for the display command frame parser.
`ifndef DISPLAY_COMMAND_FRAME_PARSER_DEFINES_SVH
`define DISPLAY_COMMAND_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted.
`define DCFP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds across reset.
`define DCFP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCFP_ASSERT_CLK(lbl, prop, msg)
`define DCFP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### src/dcfp_pkg.sv
// Shared types, constants and keyword table of the display command frame parser.
package dcfp_pkg;

  localparam int DCFP_PAYLOAD_LIMIT = 100;

  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [7:0] END_BYTE   = 8'h54;

  localparam int KW_COUNT   = 7;
  localparam int KW_MAX_LEN = 11;
  localparam int IDX_W      = 7;
  localparam int MODE_W     = 3;

  // Keywords, left-justified and zero padded to the longest one
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    {"Automatic",   16'h0},
    {"Manual",      40'h0},
    {"System",      40'h0},
    {"SemiAuto",    24'h0},
    {"Tests",       48'h0},
    {"Update",      40'h0},
    {"Calibration"}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd9, 4'd6, 4'd6, 4'd8, 4'd5, 4'd6, 4'd11
  };

  typedef enum logic [5:0] {
    PH_WAIT    = 6'b000001,
    PH_TYPE    = 6'b000010,
    PH_ACTION  = 6'b000100,
    PH_LENGTH  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_END     = 6'b100000
  } dcfp_phase_t;

  typedef struct packed {
    logic              payload_valid;
    logic [IDX_W-1:0]  payload_index;
    logic [7:0]        payload_byte;
    logic              frame_done;
    logic              frame_dropped;
    logic [7:0]        frame_type;
    logic [7:0]        frame_action;
    logic [IDX_W-1:0]  frame_length;
    logic [MODE_W-1:0] menu_mode;
    logic              mode_entered;
  } dcfp_result_t;

  // Character idx of keyword k, zero past the table width
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < KW_MAX_LEN) begin
      c = KW_TEXT[k][8*(KW_MAX_LEN-1-int'(idx)) +: 8];
    end
    return c;
  endfunction

endpackage

### src/dcfp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
interface dcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dcfp_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [6:0] payload_index;
  logic [7:0] payload_byte;
  logic       frame_done;
  logic       frame_dropped;
  logic [7:0] frame_type;
  logic [7:0] frame_action;
  logic [6:0] frame_length;
  logic [2:0] menu_mode;
  logic       mode_entered;

  modport source (
    output valid, input ready,
    output payload_valid, output payload_index, output payload_byte,
    output frame_done, output frame_dropped, output frame_type,
    output frame_action, output frame_length, output menu_mode,
    output mode_entered
  );
  modport sink (
    input valid, output ready,
    input payload_valid, input payload_index, input payload_byte,
    input frame_done, input frame_dropped, input frame_type,
    input frame_action, input frame_length, input menu_mode,
    input mode_entered
  );
endinterface

### src/dcfp_kw_match.sv
// Keyword compare: per-byte mismatch mask and end-of-frame mode selection.
module dcfp_kw_match #(
  parameter int CNT_W = 7
) (
  input  logic [CNT_W-1:0]            count_i,
  input  logic [7:0]                  byte_i,
  input  logic [dcfp_pkg::KW_COUNT-1:0] hits_i,
  input  logic [CNT_W-1:0]            length_i,
  output logic [dcfp_pkg::KW_COUNT-1:0] miss_o,
  output logic                        hit_o,
  output logic [dcfp_pkg::MODE_W-1:0] mode_o
);
  import dcfp_pkg::*;

  logic [3:0] idx;

  assign idx = count_i[3:0];

  // A keyword drops out when the byte at its position differs
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      miss_o[k] = (9'(count_i) < 9'(KW_LEN[k])) && (kw_char(3'(k), idx) != byte_i);
    end
  end

  // Surviving keyword that fits in the payload picks the mode
  always_comb begin
    hit_o  = 1'b0;
    mode_o = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (hits_i[k] && (9'(length_i) >= 9'(KW_LEN[k]))) begin
        hit_o  = 1'b1;
        mode_o = MODE_W'(k + 1);
      end
    end
  end

endmodule

### src/dcfp_parser.sv
// Frame parser state and per-byte result logic.
module dcfp_parser #(
  parameter int PAYLOAD_LIMIT = dcfp_pkg::DCFP_PAYLOAD_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output dcfp_pkg::dcfp_result_t res_o
);
  import dcfp_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_LIMIT);

  dcfp_phase_t         phase_r, phase_nxt;
  logic [7:0]          type_r, type_nxt;
  logic [7:0]          action_r, action_nxt;
  logic [CNT_W-1:0]    len_r, len_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [KW_COUNT-1:0] hits_r, hits_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;

  logic [KW_COUNT-1:0] kw_miss;
  logic                kw_hit;
  logic [MODE_W-1:0]   kw_mode;
  logic                last_byte;

  dcfp_kw_match #(.CNT_W(CNT_W)) u_kw (
    .count_i  (count_r),
    .byte_i   (byte_i),
    .hits_i   (hits_r),
    .length_i (len_r),
    .miss_o   (kw_miss),
    .hit_o    (kw_hit),
    .mode_o   (kw_mode)
  );

  assign last_byte = ((CNT_W+1)'(count_r) + (CNT_W+1)'(1)) >= (CNT_W+1)'(len_r);

  // Next state and result for the byte in hand
  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    action_nxt = action_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    hits_nxt   = hits_r;
    mode_nxt   = mode_r;
    res_o      = '0;

    unique case (phase_r)
      PH_WAIT: begin
        if (byte_i == START_BYTE) begin
          hits_nxt  = '1;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_nxt  = byte_i;
        phase_nxt = PH_ACTION;
      end
      PH_ACTION: begin
        action_nxt = byte_i;
        phase_nxt  = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (9'(byte_i) < 9'(PAYLOAD_LIMIT)) begin
          len_nxt   = CNT_W'(byte_i);
          count_nxt = '0;
          phase_nxt = (byte_i == 8'h00) ? PH_END : PH_PAYLOAD;
        end else begin
          res_o.frame_dropped = 1'b1;
          phase_nxt           = PH_WAIT;
        end
      end
      PH_PAYLOAD: begin
        hits_nxt            = hits_r & ~kw_miss;
        res_o.payload_valid = 1'b1;
        res_o.payload_index = IDX_W'(count_r);
        res_o.payload_byte  = byte_i;
        count_nxt           = count_r + CNT_W'(1);
        if (last_byte) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        if (byte_i == END_BYTE) begin
          res_o.frame_done   = 1'b1;
          res_o.frame_type   = type_r;
          res_o.frame_action = action_r;
          res_o.frame_length = IDX_W'(len_r);
          if (kw_hit) begin
            mode_nxt           = kw_mode;
            res_o.mode_entered = 1'b1;
          end
        end else begin
          res_o.frame_dropped = 1'b1;
        end
        phase_nxt = PH_WAIT;
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase

    res_o.menu_mode = mode_nxt;
  end

  // State registers advance once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      type_r   <= '0;
      action_r <= '0;
      len_r    <= '0;
      count_r  <= '0;
      hits_r   <= '1;
      mode_r   <= '0;
    end else if (step_i) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      action_r <= action_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      hits_r   <= hits_nxt;
      mode_r   <= mode_nxt;
    end
  end

endmodule

### src/display_command_frame_parser.sv
// A byte taken from the input waits in the input register until the parser steps on it;
// its result is held in the result register until it transfers on the out channel.
// Throughput: one byte per cycle while the out channel does not stall; the parser
// state loop updates once per byte. The input register and the result register let a
// byte enter while a result waits. Reset (rst_n low, synchronous) empties both registers,
// returns the parser to waiting for a start byte and sets the menu mode to idle.
module display_command_frame_parser #(
  parameter int PAYLOAD_LIMIT = dcfp_pkg::DCFP_PAYLOAD_LIMIT
) (
  input logic       clk,
  input logic       rst_n,
  dcfp_in_if.sink   in_if,
  dcfp_out_if.source out_if
);
  import dcfp_pkg::*;

  `include "display_command_frame_parser_defines.svh"

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         out_valid_r;
  dcfp_result_t res_r;
  dcfp_result_t res;
  logic         out_take;
  logic         step;

  // Pipeline advance
  assign out_take    = !out_valid_r || out_if.ready;
  assign step        = s1_valid_r && out_take;
  assign in_if.ready = !s1_valid_r || step;

  dcfp_parser #(.PAYLOAD_LIMIT(PAYLOAD_LIMIT)) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (s1_byte_r),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r <= in_if.rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.payload_valid = res_r.payload_valid;
  assign out_if.payload_index = res_r.payload_index;
  assign out_if.payload_byte  = res_r.payload_byte;
  assign out_if.frame_done    = res_r.frame_done;
  assign out_if.frame_dropped = res_r.frame_dropped;
  assign out_if.frame_type    = res_r.frame_type;
  assign out_if.frame_action  = res_r.frame_action;
  assign out_if.frame_length  = res_r.frame_length;
  assign out_if.menu_mode     = res_r.menu_mode;
  assign out_if.mode_entered  = res_r.mode_entered;

  // Checks
  `DCFP_ASSERT_CLK(a_payload_not_close,
    out_valid_r |-> !(res_r.payload_valid && (res_r.frame_done || res_r.frame_dropped)),
    "payload byte reported together with frame close")
  `DCFP_ASSERT_CLK(a_entry_needs_done,
    (out_valid_r && res_r.mode_entered) |-> res_r.frame_done,
    "mode entry without a completed frame")
  `DCFP_ASSERT_CLK(a_stall_blocks_input,
    (s1_valid_r && out_valid_r && !out_if.ready) |-> !in_if.ready,
    "input taken while both registers are full")
  `DCFP_ASSERT_RST(a_reset_empties,
    !rst_n |=> (!out_valid_r && !s1_valid_r),
    "pipeline not empty after reset")

endmodule

### test/tb_top.sv
// Self-checking testbench for the display command frame parser: directed rows, then random frames.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcfp_pkg::*;

  // One directed stimulus row; res is used only when typed is set
  typedef struct {
    logic [7:0]   rx;
    bit           typed;
    dcfp_result_t res;
  } stim_row_t;

  localparam dcfp_result_t NO_REPORT = '0;
  localparam int DIR_ROWS = 25;

  logic clk = 1'b0;
  logic rst_n;

  dcfp_in_if  in_ch ();
  dcfp_out_if out_ch ();

  display_command_frame_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser image kept by the testbench
  string       keywords [KW_COUNT] = '{"Automatic", "Manual", "System", "SemiAuto",
                                       "Tests", "Update", "Calibration"};
  dcfp_phase_t parse_phase = PH_WAIT;
  logic [7:0]  frame_type_q = '0;
  logic [7:0]  frame_action_q = '0;
  logic [7:0]  frame_len_q = '0;
  logic [7:0]  payload_pos = '0;
  logic [6:0]  keyword_alive = '1;
  logic [2:0]  mode_q = '0;

  dcfp_result_t awaited_reports [$];
  int           errors = 0;
  int           bytes_sent = 0;
  int           frame_bytes = 0;
  int           idle_phase = 0;

  // Side information of the byte currently offered on the input channel
  bit           cur_typed = 1'b0;
  dcfp_result_t cur_res = '0;

  stim_row_t    dir_rows [DIR_ROWS];

  // Advance the parser image by one byte and return the report it produces
  function automatic dcfp_result_t next_report(input logic [7:0] b);
    dcfp_result_t r;
    r = '0;
    case (parse_phase)
      PH_WAIT: begin
        if (b == START_BYTE) begin
          keyword_alive = '1;
          parse_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        frame_type_q = b;
        parse_phase = PH_ACTION;
      end
      PH_ACTION: begin
        frame_action_q = b;
        parse_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        frame_len_q = b;
        if (int'(b) < DCFP_PAYLOAD_LIMIT) begin
          payload_pos = '0;
          parse_phase = (b == 8'h00) ? PH_END : PH_PAYLOAD;
        end else begin
          r.frame_dropped = 1'b1;
          parse_phase = PH_WAIT;
        end
      end
      PH_PAYLOAD: begin
        // a keyword stays alive while every byte so far matches its text
        for (int k = 0; k < KW_COUNT; k++) begin
          if (int'(payload_pos) < keywords[k].len() &&
              keywords[k][int'(payload_pos)] != b) begin
            keyword_alive[k] = 1'b0;
          end
        end
        r.payload_valid = 1'b1;
        r.payload_index = payload_pos[6:0];
        r.payload_byte  = b;
        if (int'(payload_pos) + 1 >= int'(frame_len_q)) parse_phase = PH_END;
        payload_pos = payload_pos + 8'd1;
      end
      PH_END: begin
        if (b == END_BYTE) begin
          r.frame_done   = 1'b1;
          r.frame_type   = frame_type_q;
          r.frame_action = frame_action_q;
          r.frame_length = frame_len_q[6:0];
          for (int k = 0; k < KW_COUNT; k++) begin
            if (keyword_alive[k] && int'(frame_len_q) >= keywords[k].len()) begin
              mode_q = 3'(k + 1);
              r.mode_entered = 1'b1;
            end
          end
        end else begin
          r.frame_dropped = 1'b1;
        end
        parse_phase = PH_WAIT;
      end
      default: parse_phase = PH_WAIT;
    endcase
    r.menu_mode = mode_q;
    return r;
  endfunction

  // Frame report with no payload echo, for the typed rows
  function automatic dcfp_result_t report(input logic done, input logic dropped,
                                          input logic [7:0] ftype, input logic [7:0] faction,
                                          input logic [6:0] flen, input logic [2:0] mode,
                                          input logic entered);
    dcfp_result_t r;
    r = '0;
    r.frame_done    = done;
    r.frame_dropped = dropped;
    r.frame_type    = ftype;
    r.frame_action  = faction;
    r.frame_length  = flen;
    r.menu_mode     = mode;
    r.mode_entered  = entered;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Offer one byte from a falling edge until its transfer; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit typed, input dcfp_result_t res);
    int gap_pct;
    gap_pct = (idle_phase == 1) ? 78 : (idle_phase == 3) ? 19 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    cur_typed     <= typed;
    cur_res       <= res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    idle_phase = (bytes_sent / 50) % 4;
    @(negedge clk);
  endtask

  // One random frame, mostly well formed, with optional leading noise
  task automatic send_random_frame();
    logic [7:0] body [$];
    logic [7:0] end_b;
    int         kind;
    int         k;
    int         len;
    int         n;
    int         pos;
    body = {};
    if ($urandom_range(0, 99) < 20) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
    end
    kind = $urandom_range(0, 99);
    k    = $urandom_range(0, KW_COUNT - 1);
    if (kind < 5) begin
      len = $urandom_range(DCFP_PAYLOAD_LIMIT, 255);
    end else if (kind < 8) begin
      len = $urandom_range(DCFP_PAYLOAD_LIMIT - 2, DCFP_PAYLOAD_LIMIT - 1);
    end else if (kind < 40) begin
      // keyword payload: exact with a tail, truncated, or with one byte corrupted
      for (int i = 0; i < keywords[k].len(); i++) body.push_back(keywords[k][i]);
      n = $urandom_range(0, 99);
      if (n < 20) begin
        body = body[0:$urandom_range(0, body.size() - 2)];
      end else if (n < 40) begin
        pos = $urandom_range(0, body.size() - 1);
        body[pos] = body[pos] ^ 8'($urandom_range(1, 255));
      end else begin
        repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(0, 255)));
      end
      len = body.size();
    end else begin
      len = $urandom_range(0, 12);
    end
    if (len < DCFP_PAYLOAD_LIMIT) begin
      while (body.size() < len) body.push_back(8'($urandom_range(0, 255)));
    end

    send_byte(START_BYTE, 1'b0, NO_REPORT);
    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_REPORT);
    send_byte(8'(len), 1'b0, NO_REPORT);
    frame_bytes += 4;
    if (len < DCFP_PAYLOAD_LIMIT) begin
      foreach (body[i]) send_byte(body[i], 1'b0, NO_REPORT);
      end_b = END_BYTE;
      if ($urandom_range(0, 99) < 12) begin
        end_b = 8'($urandom_range(0, 255));
        if (end_b == END_BYTE) end_b = START_BYTE;
      end
      send_byte(end_b, 1'b0, NO_REPORT);
      frame_bytes += body.size() + 1;
    end
  endtask

  // Result receiver: ready changes at the falling edge
  initial begin
    int stall_pct;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall_pct = (idle_phase == 2) ? 78 : (idle_phase == 3) ? 19 : 0;
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    dcfp_result_t want;
    dcfp_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = next_report(in_ch.rx_byte);
        awaited_reports.push_back(cur_typed ? cur_res : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.payload_valid = out_ch.payload_valid;
        got.payload_index = out_ch.payload_index;
        got.payload_byte  = out_ch.payload_byte;
        got.frame_done    = out_ch.frame_done;
        got.frame_dropped = out_ch.frame_dropped;
        got.frame_type    = out_ch.frame_type;
        got.frame_action  = out_ch.frame_action;
        got.frame_length  = out_ch.frame_length;
        got.menu_mode     = out_ch.menu_mode;
        got.mode_entered  = out_ch.mode_entered;
        if (awaited_reports.size() == 0) begin
          $display("%0t: result transfer with none awaited, expected nothing, actual %h",
                   $time, got);
          errors++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("payload_valid", want.payload_valid, got.payload_valid);
          check_field("payload_index", want.payload_index, got.payload_index);
          check_field("payload_byte", want.payload_byte, got.payload_byte);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("frame_dropped", want.frame_dropped, got.frame_dropped);
          check_field("frame_type", want.frame_type, got.frame_type);
          check_field("frame_action", want.frame_action, got.frame_action);
          check_field("frame_length", want.frame_length, got.frame_length);
          check_field("menu_mode", want.menu_mode, got.menu_mode);
          check_field("mode_entered", want.mode_entered, got.mode_entered);
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;

    dir_rows = '{
      // bytes outside a frame are ignored
      '{8'h00, 1'b1, NO_REPORT},
      // oversized length drops the frame
      '{8'h55, 1'b1, NO_REPORT},
      '{8'hFF, 1'b1, NO_REPORT},
      '{8'h00, 1'b1, NO_REPORT},
      '{8'h64, 1'b1, report(1'b0, 1'b1, 8'h00, 8'h00, 7'd0, 3'd0, 1'b0)},
      // zero length goes straight to the end byte
      '{8'h55, 1'b1, NO_REPORT},
      '{8'h00, 1'b1, NO_REPORT},
      '{8'hFF, 1'b1, NO_REPORT},
      '{8'h00, 1'b1, NO_REPORT},
      '{8'h54, 1'b1, report(1'b1, 1'b0, 8'h00, 8'hFF, 7'd0, 3'd0, 1'b0)},
      // bad end byte, itself a start byte that must not open a frame
      '{8'h55, 1'b1, NO_REPORT},
      '{8'h12, 1'b1, NO_REPORT},
      '{8'h34, 1'b1, NO_REPORT},
      '{8'h00, 1'b1, NO_REPORT},
      '{8'h55, 1'b1, report(1'b0, 1'b1, 8'h00, 8'h00, 7'd0, 3'd0, 1'b0)},
      // keyword frame "Tests" enters mode 5
      '{8'h55, 1'b1, NO_REPORT},
      '{8'hAA, 1'b1, NO_REPORT},
      '{8'hBB, 1'b1, NO_REPORT},
      '{8'h05, 1'b1, NO_REPORT},
      '{8'h54, 1'b0, NO_REPORT},
      '{8'h65, 1'b0, NO_REPORT},
      '{8'h73, 1'b0, NO_REPORT},
      '{8'h74, 1'b0, NO_REPORT},
      '{8'h73, 1'b0, NO_REPORT},
      '{8'h54, 1'b1, report(1'b1, 1'b0, 8'hAA, 8'hBB, 7'd5, 3'd5, 1'b1)}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);

    while (frame_bytes < 500) send_random_frame();
    in_ch.valid <= 1'b0;

    // drain, then keep watching for stray results
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
